// ----- hw/rtl/isqs_pkg.sv -----
// ----------------------------------------------------------------------------
// Input-queued switch scheduler package
// Shared sizes, field widths and item types of the scheduler.
// ----------------------------------------------------------------------------
package isqs_pkg;

  localparam int PORTS      = 8;
  localparam int BUF_DEPTH  = 4;

  localparam int MASK_W     = 8;
  localparam int DESTS_W    = 24;
  localparam int PORT_W     = 3;
  localparam int DELAY_W    = 16;
  localparam int STAMP_W    = 32;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_PAD_W  = OUT_DATA_W - 2 * PORT_W - DELAY_W;

  localparam int PIDX_W     = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int ADDR_W     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int FILL_W     = $clog2(BUF_DEPTH + 1);
  localparam int SUM_W      = FILL_W + 1;
  localparam int ENTRY_W    = PORT_W + STAMP_W;

  localparam logic [STAMP_W-1:0] DELAY_SAT_AT = 32'd65534;
  localparam logic [DELAY_W-1:0] DELAY_MAX    = 16'hFFFF;

  typedef struct packed {
    logic [PORTS-1:0]        mask;
    logic [PORTS*PORT_W-1:0] dests;
  } slot_t;

  typedef struct packed {
    logic [PORT_W-1:0]  dest;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

endpackage

// ----- hw/rtl/isqs_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module isqs_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 4,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hw/rtl/isqs_front.sv -----
// ----------------------------------------------------------------------------
// Scheduler front end
// Accepts slot items, strips ports beyond the switch size and holds them in
// a two-entry queue for the scheduling engine.
// ----------------------------------------------------------------------------
module isqs_front import isqs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  output logic                 slot_valid,
  output slot_t                slot,
  input  logic                 slot_ready
);

  slot_t      q_r [2];
  slot_t      slot_in;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign slot_in.mask  = in_tdata[PORTS-1:0];
  assign slot_in.dests = in_tdata[MASK_W +: PORTS*PORT_W];

  assign in_tready  = (cnt_r != 2'd2);
  assign slot_valid = (cnt_r != 2'd0);
  assign slot       = q_r[rd_ptr_r];
  assign push       = in_tvalid && in_tready;
  assign pop        = slot_valid && slot_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= slot_in;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- hw/rtl/isqs_back.sv -----
// ----------------------------------------------------------------------------
// Scheduler engine
// Appends slot arrivals to the per-port FIFOs, grants head-of-line packets
// in fixed priority and emits one departure item per cycle unless stalled.
// ----------------------------------------------------------------------------
module isqs_back import isqs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  slot_valid,
  input  slot_t                 slot,
  output logic                  slot_ready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_GRANT, S_EMIT} state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   head_r [PORTS];
  logic [ADDR_W-1:0]   head_nxt [PORTS];
  logic [FILL_W-1:0]   fill_r [PORTS];
  logic [FILL_W-1:0]   fill_nxt [PORTS];
  logic [STAMP_W-1:0]  slot_cnt_r, slot_cnt_nxt;
  logic [PORTS-1:0]    grant_r, grant_nxt;
  entry_t              head_ent_r [PORTS];
  entry_t              rd_ent [PORTS];

  logic [PORTS-1:0]    wr_en;
  logic [ADDR_W-1:0]   wr_addr [PORTS];
  entry_t              wr_ent [PORTS];
  logic [SUM_W-1:0]    tail_sum [PORTS];

  logic                out_valid_r, out_valid_nxt;
  logic [PORT_W-1:0]   out_in_port_r, out_in_port_nxt;
  logic [PORT_W-1:0]   out_port_r, out_port_nxt;
  logic [DELAY_W-1:0]  out_delay_r, out_delay_nxt;
  logic                out_last_r, out_last_nxt;

  for (genvar p = 0; p < PORTS; p++) begin : g_fifo
    isqs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (BUF_DEPTH)
    ) u_ram (
      .clk     (clk),
      .wr_en   (wr_en[p]),
      .wr_addr (wr_addr[p]),
      .wr_data (wr_ent[p]),
      .rd_addr (head_r[p]),
      .rd_data (rd_ent[p])
    );
  end

  assign slot_ready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_delay_r, out_port_r, out_in_port_r};

  always_comb begin
    for (int p = 0; p < PORTS; p++) begin
      tail_sum[p] = SUM_W'(head_r[p]) + SUM_W'(fill_r[p]);
      if (tail_sum[p] >= SUM_W'(BUF_DEPTH)) begin
        tail_sum[p] = tail_sum[p] - SUM_W'(BUF_DEPTH);
      end
      wr_addr[p]      = tail_sum[p][ADDR_W-1:0];
      wr_en[p]        = (state_r == S_IDLE) && slot_valid && slot.mask[p] &&
                        (fill_r[p] != FILL_W'(BUF_DEPTH));
      wr_ent[p].dest  = slot.dests[p*PORT_W +: PORT_W];
      wr_ent[p].stamp = slot_cnt_r;
    end
  end

  always_comb begin
    logic [7:0]         busy;
    logic [PORTS-1:0]   gnt;
    logic [PORTS-1:0]   rest;
    logic [PIDX_W-1:0]  sel;
    logic [STAMP_W-1:0] diff;

    state_nxt       = state_r;
    head_nxt        = head_r;
    fill_nxt        = fill_r;
    slot_cnt_nxt    = slot_cnt_r;
    grant_nxt       = grant_r;
    out_valid_nxt   = out_valid_r;
    out_in_port_nxt = out_in_port_r;
    out_port_nxt    = out_port_r;
    out_delay_nxt   = out_delay_r;
    out_last_nxt    = out_last_r;
    busy            = '0;
    gnt             = '0;
    rest            = grant_r & (grant_r - 1'b1);
    sel             = '0;
    diff            = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        for (int p = 0; p < PORTS; p++) begin
          if (wr_en[p]) begin
            fill_nxt[p] = fill_r[p] + 1'b1;
          end
        end
        if (slot_valid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_GRANT;
      end
      S_GRANT: begin
        for (int p = 0; p < PORTS; p++) begin
          if ((fill_r[p] != '0) && !busy[rd_ent[p].dest]) begin
            gnt[p]              = 1'b1;
            busy[rd_ent[p].dest] = 1'b1;
            head_nxt[p]         = (head_r[p] == ADDR_W'(BUF_DEPTH - 1)) ? '0 :
                                  head_r[p] + 1'b1;
            fill_nxt[p]         = fill_r[p] - 1'b1;
          end
        end
        grant_nxt = gnt;
        if (gnt == '0) begin
          slot_cnt_nxt = slot_cnt_r + 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        for (int p = PORTS - 1; p >= 0; p--) begin
          if (grant_r[p]) begin
            sel = PIDX_W'(p);
          end
        end
        if (!out_valid_r || out_tready) begin
          diff            = slot_cnt_r - head_ent_r[sel].stamp;
          out_valid_nxt   = 1'b1;
          out_in_port_nxt = PORT_W'(sel);
          out_port_nxt    = head_ent_r[sel].dest;
          out_delay_nxt   = (diff >= DELAY_SAT_AT) ? DELAY_MAX : diff[DELAY_W-1:0] + 1'b1;
          out_last_nxt    = (rest == '0);
          grant_nxt       = rest;
          if (rest == '0) begin
            slot_cnt_nxt = slot_cnt_r + 1'b1;
            state_nxt    = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_GRANT) begin
      head_ent_r <= rd_ent;
    end
    out_in_port_r <= out_in_port_nxt;
    out_port_r    <= out_port_nxt;
    out_delay_r   <= out_delay_nxt;
    out_last_r    <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_cnt_r  <= '0;
      grant_r     <= '0;
      out_valid_r <= 1'b0;
      for (int p = 0; p < PORTS; p++) begin
        head_r[p] <= '0;
        fill_r[p] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      slot_cnt_r  <= slot_cnt_nxt;
      grant_r     <= grant_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
    end
  end

  a_grant_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_READ) |-> (grant_r == '0))
    else $error("Grants are pending outside the emit phase.");

  a_grant_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (grant_r != '0))
    else $error("Emit phase entered with no grants.");

  a_slot_adv: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (slot_cnt_r != $past(slot_cnt_r))) |->
    ($past(state_r) == S_GRANT || $past(state_r) == S_EMIT))
    else $error("Slot counter advanced outside the end of a slot.");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EMIT))
    else $error("Result item raised outside the emit phase.");

endmodule

// ----- hw/rtl/input_queued_switch_scheduler.sv -----
// ----------------------------------------------------------------------------
// Input-queued switch scheduler
// Per-port head-of-line FIFOs with fixed-priority output grants.
// ----------------------------------------------------------------------------
// Each input item is one time slot. Its arrivals are written to the per-port
// FIFO memories in the IDLE state, the heads are read in READ and granted in
// GRANT, after which one departure item leaves per cycle unless the output
// stalls, through the single output register. A slot with no grants emits
// nothing. A two-entry queue in front of the engine takes further slots
// while one is being scheduled.
module input_queued_switch_scheduler import isqs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // arrival_mask, arrival_dests
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // in_port, out_port, delay
  output logic                  out_tlast
);

  slot_t slot;
  logic  slot_valid;
  logic  slot_ready;

  isqs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .slot_valid (slot_valid),
    .slot       (slot),
    .slot_ready (slot_ready)
  );

  isqs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .slot_valid (slot_valid),
    .slot       (slot),
    .slot_ready (slot_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
